// ===== rtl/core/bnpc_pkg.sv =====
// Package: shared types and constants for the blended nearest palette color block.
`timescale 1ns / 1ps

package bnpc_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int IDX_W  = 8;
	localparam int CHAN_W = 8;
	localparam int DIST_W = 24;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic BLEND_HALF    = 1'b0;
	localparam logic BLEND_QUARTER = 1'b1;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  entry_index;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [IDX_W-1:0]  first_color;
		logic [IDX_W-1:0]  second_color;
		logic              blend_mode;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]  nearest_index;
		logic [DIST_W-1:0] best_distance;
	} out_word_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_QUERY,
		CMD_SAME
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [IDX_W-1:0]    addr;
		logic [3*CHAN_W-1:0] color;
		logic [IDX_W-1:0]    a_idx;
		logic [IDX_W-1:0]    b_idx;
		logic                a_ok;
		logic                b_ok;
		logic                mode;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RD_A,
		B_RD_B,
		B_SCAN,
		B_DRAIN,
		B_DONE
	} back_state_t;

endpackage

// ===== rtl/core/bnpc_front.sv =====
// Front end: accepts input words and classifies them into commands.
`timescale 1ns / 1ps

module bnpc_front #(
	parameter int PALETTE_ENTRIES = bnpc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic              req_valid,
	output logic              req_ready,
	input  bnpc_pkg::in_word_t req,
	input  logic              q_full,
	output logic              q_push,
	output bnpc_pkg::cmd_t    q_data
);
	import bnpc_pkg::*;

	localparam logic [IDX_W:0] ENT = (IDX_W+1)'(PALETTE_ENTRIES);

	logic load_ok;
	logic a_ok;
	logic b_ok;

	assign load_ok = {1'b0, req.entry_index} < ENT;
	assign a_ok    = {1'b0, req.first_color} < ENT;
	assign b_ok    = {1'b0, req.second_color} < ENT;

	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full && !(req.op == OP_LOAD && !load_ok);

	always_comb begin
		q_data       = '0;
		q_data.color = {req.red, req.green, req.blue};
		q_data.a_idx = req.first_color;
		q_data.b_idx = req.second_color;
		q_data.a_ok  = a_ok;
		q_data.b_ok  = b_ok;
		q_data.mode  = req.blend_mode;
		if (req.op == OP_LOAD) begin
			q_data.kind = CMD_LOAD;
			q_data.addr = req.entry_index;
		end else if (req.first_color == req.second_color) begin
			q_data.kind = CMD_SAME;
			q_data.addr = req.first_color;
		end else begin
			q_data.kind = CMD_QUERY;
			q_data.addr = req.first_color;
		end
	end

endmodule

// ===== rtl/core/bnpc_queue.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps

module bnpc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  bnpc_pkg::q_ctl_t  ctl,
	input  bnpc_pkg::cmd_t    wr_data,
	output bnpc_pkg::cmd_t    head,
	output bnpc_pkg::q_stat_t stat
);
	import bnpc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = count_q == 2'd2;
	assign stat.empty = count_q == 2'd0;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({ctl.push, ctl.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/bnpc_back.sv =====
// Back end: palette memory, blend, pipelined distance scan and result register.
`timescale 1ns / 1ps

module bnpc_back #(
	parameter int PALETTE_ENTRIES = bnpc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bnpc_pkg::cmd_t     head,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bnpc_pkg::out_word_t rsp
);
	import bnpc_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

	function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic mode);
		logic [CHAN_W+1:0] s;
		begin
			if (mode == BLEND_QUARTER) begin
				s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, b};
				blend = s[CHAN_W+1:2];
			end else begin
				s = {2'b00, a} + {2'b00, b};
				blend = s[CHAN_W:1];
			end
		end
	endfunction

	function automatic logic [2*CHAN_W-1:0] sqd(input logic [CHAN_W-1:0] x,
		input logic [CHAN_W-1:0] y);
		logic [CHAN_W-1:0] d;
		begin
			d = (x > y) ? x - y : y - x;
			sqd = (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
		end
	endfunction

	logic [3*CHAN_W-1:0] mem [PALETTE_ENTRIES];
	logic [3*CHAN_W-1:0] mem_rd_q;

	back_state_t state_q, state_nxt;
	cmd_t        cmd_q;
	logic [3*CHAN_W-1:0] col_a_q;
	logic [3*CHAN_W-1:0] col_b;
	logic [CHAN_W-1:0]   tgt_r_q, tgt_g_q, tgt_b_q;
	logic [AW-1:0]       k_q;

	logic          mem_we;
	logic [AW-1:0] rd_addr;
	logic          issue;
	logic          slot_free;
	logic          rsp_load;
	out_word_t     rsp_next;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                last_s1, last_s2, last_s3, last_s4;
	logic [AW-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic [2*CHAN_W-1:0] sqr_s2, sqg_s2, sqb_s2;
	logic [DIST_W-1:0]   wr_s3, wg_s3, wb_s3;
	logic [DIST_W-1:0]   dist_s4;

	logic [DIST_W-1:0] best_d_q;
	logic [AW-1:0]     best_i_q;
	logic              rsp_valid_q;
	out_word_t         rsp_q;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign col_b     = cmd_q.b_ok ? mem_rd_q : '0;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = k_q;
		issue     = 1'b0;
		rsp_load  = 1'b0;
		rsp_next  = '0;
		unique case (state_q)
			B_IDLE: begin
				rd_addr = head.a_idx[AW-1:0];
				if (!q_empty) begin
					unique case (head.kind)
						CMD_LOAD: begin
							mem_we = 1'b1;
							q_pop  = 1'b1;
						end
						CMD_SAME: begin
							if (slot_free) begin
								rsp_load               = 1'b1;
								rsp_next.nearest_index = head.addr;
								rsp_next.best_distance = '0;
								q_pop                  = 1'b1;
							end
						end
						CMD_QUERY: begin
							q_pop     = 1'b1;
							state_nxt = B_RD_A;
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			B_RD_A: begin
				rd_addr   = cmd_q.b_idx[AW-1:0];
				state_nxt = B_RD_B;
			end
			B_RD_B: begin
				state_nxt = B_SCAN;
			end
			B_SCAN: begin
				issue = 1'b1;
				if (k_q == LAST) begin
					state_nxt = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (v_s4 && last_s4) begin
					state_nxt = B_DONE;
				end
			end
			B_DONE: begin
				if (slot_free) begin
					rsp_load               = 1'b1;
					rsp_next.nearest_index = IDX_W'(best_i_q);
					rsp_next.best_distance = best_d_q;
					state_nxt              = B_IDLE;
				end
			end
			default: state_nxt = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.addr[AW-1:0]] <= head.color;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			cmd_q <= head;
		end
		if (state_q == B_RD_A) begin
			col_a_q <= cmd_q.a_ok ? mem_rd_q : '0;
		end
		if (state_q == B_RD_B) begin
			tgt_r_q <= blend(col_a_q[23:16], col_b[23:16], cmd_q.mode);
			tgt_g_q <= blend(col_a_q[15:8], col_b[15:8], cmd_q.mode);
			tgt_b_q <= blend(col_a_q[7:0], col_b[7:0], cmd_q.mode);
		end
		idx_s1  <= k_q;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		idx_s4  <= idx_s3;
		sqr_s2  <= sqd(mem_rd_q[23:16], tgt_r_q);
		sqg_s2  <= sqd(mem_rd_q[15:8], tgt_g_q);
		sqb_s2  <= sqd(mem_rd_q[7:0], tgt_b_q);
		wr_s3   <= DIST_W'(sqr_s2) * DIST_W'(54);
		wg_s3   <= DIST_W'(sqg_s2) * DIST_W'(183);
		wb_s3   <= DIST_W'(sqb_s2) * DIST_W'(19);
		dist_s4 <= wr_s3 + wg_s3 + wb_s3;
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			last_s3     <= 1'b0;
			last_s4     <= 1'b0;
			best_d_q    <= '1;
			best_i_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == B_RD_B) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + AW'(1);
			end
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			last_s1 <= issue && (k_q == LAST);
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			if (state_q == B_RD_B) begin
				best_d_q <= '1;
				best_i_q <= '0;
			end else if (v_s4 && (dist_s4 < best_d_q)) begin
				best_d_q <= dist_s4;
				best_i_q <= idx_s4;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/blended_nearest_palette_color.sv =====
// Top level: blended nearest palette color search.
//
// Channel  Dir  Handshake               Word
// req      in   req_valid / req_ready   in_word_t (palette load or blend query)
// rsp      out  rsp_valid / rsp_ready   out_word_t (one per query)
//
// A load waits only for a free queue slot.
// A query makes two reads for the blended colors, then one palette read per
// cycle through the single memory read port, a four-stage distance pipeline
// and the result register.
// A query with equal indices skips the palette scan. Reset clears control only;
// the palette is undefined until loaded. A stalled rsp holds the back end.
`timescale 1ns / 1ps

module blended_nearest_palette_color #(
	parameter int PALETTE_ENTRIES = bnpc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bnpc_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output bnpc_pkg::out_word_t rsp
);
	import bnpc_pkg::*;

	q_ctl_t  q_ctl;
	q_stat_t q_stat;
	cmd_t    q_wr;
	cmd_t    q_head;

	bnpc_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_stat.full),
		.q_push    (q_ctl.push),
		.q_data    (q_wr)
	);

	bnpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (q_ctl),
		.wr_data (q_wr),
		.head    (q_head),
		.stat    (q_stat)
	);

	bnpc_back #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_stat.empty),
		.q_pop     (q_ctl.pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== dv/bnpc_checker.sv =====
// Checker: predicts each query's nearest palette color and compares the rsp words.
`timescale 1ns / 1ps

module bnpc_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  bnpc_pkg::in_word_t  req,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  bnpc_pkg::out_word_t rsp,
	output int                  fail_count,
	output int                  pending
);

	import bnpc_pkg::*;

	localparam int unsigned W_RED   = 54;
	localparam int unsigned W_GREEN = 183;
	localparam int unsigned W_BLUE  = 19;

	logic [3*CHAN_W-1:0] palette_copy [PALETTE_ENTRIES_DEF];
	out_word_t           pending_nearest [$];
	int                  fails = 0;
	int                  waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic int unsigned sq_dist(input int unsigned x, input int unsigned y);
		int unsigned d;
		d = (x > y) ? x - y : y - x;
		return d * d;
	endfunction

	function automatic out_word_t nearest_color(input logic [IDX_W-1:0] a_idx,
		input logic [IDX_W-1:0] b_idx, input logic mode);
		out_word_t           res;
		logic [3*CHAN_W-1:0] ca, cb, c;
		int unsigned         target [3];
		int unsigned         av, bv, best, d;
		res.nearest_index = a_idx;
		res.best_distance = '0;
		if (a_idx == b_idx)
			return res;
		ca = palette_copy[a_idx];
		cb = palette_copy[b_idx];
		// index 0 blue, 1 green, 2 red
		for (int ch = 0; ch < 3; ch++) begin
			av = 32'(ca[ch*CHAN_W +: CHAN_W]);
			bv = 32'(cb[ch*CHAN_W +: CHAN_W]);
			target[ch[1:0]] = (mode == BLEND_QUARTER) ? (av + 3 * bv) / 4 : (av + bv) / 2;
		end
		best = 32'hFFFF_FFFF;
		for (int k = 0; k < PALETTE_ENTRIES_DEF; k++) begin
			c = palette_copy[k[IDX_W-1:0]];
			d = W_RED * sq_dist(32'(c[23:16]), target[2])
				+ W_GREEN * sq_dist(32'(c[15:8]), target[1])
				+ W_BLUE * sq_dist(32'(c[7:0]), target[0]);
			if (d < best) begin
				best = d;
				res.nearest_index = k[IDX_W-1:0];
				res.best_distance = d[DIST_W-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		out_word_t exp_word;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_nearest.size() == 0) begin
					$error("unexpected word: nearest_index %0d, best_distance %0d",
						rsp.nearest_index, rsp.best_distance);
					fails = fails + 1;
				end else begin
					exp_word = pending_nearest.pop_front();
					if (rsp.nearest_index !== exp_word.nearest_index) begin
						$error("nearest_index: expected %0d, actual %0d",
							exp_word.nearest_index, rsp.nearest_index);
						fails = fails + 1;
					end
					if (rsp.best_distance !== exp_word.best_distance) begin
						$error("best_distance: expected %0d, actual %0d",
							exp_word.best_distance, rsp.best_distance);
						fails = fails + 1;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.op == OP_LOAD)
					palette_copy[req.entry_index] = {req.red, req.green, req.blue};
				else
					pending_nearest.push_back(nearest_color(req.first_color,
						req.second_color, req.blend_mode));
			end
			waiting <= pending_nearest.size();
		end
	end

endmodule

// ===== dv/tb_blended_nearest_palette_color.sv =====
// Testbench top: drives palette loads and blend queries, handles rsp backpressure.
`timescale 1ns / 1ps

module tb_blended_nearest_palette_color;

	import bnpc_pkg::*;

	localparam int STALL_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 2500;
	localparam int DRAIN_CYCLES = 300;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_word_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_word_t rsp;
	int        fail_count;
	int        pending;
	int        stall_cycles = 0;
	int        snd_run = 0;
	bit        snd_calm = 1'b0;

	always #5 clk = ~clk;

	blended_nearest_palette_color u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	bnpc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// each run is either random gaps or back-to-back words, chosen at random
	function automatic int draw_gap(inout int run_left, inout bit calm);
		if (run_left == 0) begin
			run_left = $urandom_range(8, 40);
			calm = ($urandom_range(0, 3) == 0);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [3*CHAN_W-1:0] rand_color();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	function automatic in_word_t make_load(input logic [IDX_W-1:0] idx,
		input logic [3*CHAN_W-1:0] color);
		in_word_t w;
		w.op = OP_LOAD;
		w.entry_index = idx;
		{w.red, w.green, w.blue} = color;
		w.first_color = IDX_W'($urandom_range(0, 255));
		w.second_color = IDX_W'($urandom_range(0, 255));
		w.blend_mode = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic in_word_t make_query(input logic [IDX_W-1:0] a_idx,
		input logic [IDX_W-1:0] b_idx, input logic mode);
		in_word_t w;
		w.op = OP_QUERY;
		w.entry_index = IDX_W'($urandom_range(0, 255));
		w.red = CHAN_W'($urandom_range(0, 255));
		w.green = CHAN_W'($urandom_range(0, 255));
		w.blue = CHAN_W'($urandom_range(0, 255));
		w.first_color = a_idx;
		w.second_color = b_idx;
		w.blend_mode = mode;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		gap = draw_gap(snd_run, snd_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
	endtask

	initial begin
		int gap;
		int taken;
		int rcv_run;
		bit rcv_calm;
		taken = 0;
		rcv_run = 0;
		rcv_calm = 1'b0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(rcv_run, rcv_calm);
			// long hold so the request queue fills and req_ready drops
			if (taken == 150 || taken == 500)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [3*CHAN_W-1:0] color;
		logic [3*CHAN_W-1:0] tie_a, tie_b;
		logic [3*CHAN_W-1:0] few_colors [4];
		logic [IDX_W-1:0]    a_idx, b_idx;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		tie_a = '0;
		tie_b = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// equal indices need no palette
		send_word(make_query(8'd0, 8'd0, BLEND_HALF));
		send_word(make_query(8'd255, 8'd255, BLEND_QUARTER));

		// full palette with primaries, extremes and duplicate entries for ties
		for (int e = 0; e < PALETTE_ENTRIES_DEF; e++) begin
			case (e)
				0: color = 24'h000000;
				1: color = 24'hFF0000;
				2: color = 24'h00FF00;
				3: color = 24'h0000FF;
				51, 52, 53: color = tie_a;
				200: color = tie_b;
				255: color = 24'hFFFFFF;
				default: color = rand_color();
			endcase
			if (e == 50)
				tie_a = color;
			if (e == 100)
				tie_b = color;
			send_word(make_load(IDX_W'(e), color));
		end

		send_word(make_query(8'd0, 8'd255, BLEND_HALF));
		send_word(make_query(8'd0, 8'd255, BLEND_QUARTER));
		send_word(make_query(8'd255, 8'd0, BLEND_QUARTER));
		send_word(make_query(8'd1, 8'd2, BLEND_HALF));
		send_word(make_query(8'd2, 8'd3, BLEND_QUARTER));
		send_word(make_query(8'd3, 8'd1, BLEND_QUARTER));
		send_word(make_query(8'd100, 8'd200, BLEND_HALF));
		send_word(make_query(8'd200, 8'd100, BLEND_QUARTER));
		send_word(make_query(8'd53, 8'd51, BLEND_QUARTER));
		send_word(make_query(8'd7, 8'd7, BLEND_QUARTER));
		send_word(make_load(8'd0, 24'h808080));
		send_word(make_query(8'd0, 8'd255, BLEND_HALF));

		// middle phase: palette of four colors, so ties are common
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				for (int i = 0; i < 4; i++)
					few_colors[i] = rand_color();
				for (int e = 0; e < PALETTE_ENTRIES_DEF; e++)
					send_word(make_load(IDX_W'(e), few_colors[2'($urandom_range(0, 3))]));
			end
			for (int n = 0; n < 310; n++) begin
				if ($urandom_range(0, 99) < 35) begin
					color = (p == 1) ? few_colors[2'($urandom_range(0, 3))] : rand_color();
					send_word(make_load(IDX_W'($urandom_range(0, 255)), color));
				end else begin
					a_idx = IDX_W'($urandom_range(0, 255));
					b_idx = ($urandom_range(0, 19) == 0) ? a_idx
						: IDX_W'($urandom_range(0, 255));
					send_word(make_query(a_idx, b_idx,
						$urandom_range(0, 1) ? BLEND_QUARTER : BLEND_HALF));
				end
			end
		end
		req_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
